// ----- hdl/tfi_pkg.sv -----
// Shared constants, types and helpers for the tabulated force interpolator.
// No dependencies.
package tfi_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int MAX_POINTS  = 16;
    localparam int MAX_BEADS   = 64;

    localparam int ENT_W     = $clog2(MAX_ENTRIES);
    localparam int PT_W      = $clog2(MAX_POINTS);
    localparam int ADDR_W    = ENT_W + PT_W;
    localparam int TAB_DEPTH = MAX_ENTRIES * MAX_POINTS;

    localparam int OP_W     = 2;
    localparam int NPT_W    = 5;
    localparam int BEADN_W  = 7;
    localparam int CNT_W    = 7;
    localparam int OBEAD_W  = 6;
    localparam int DATA_W   = 32;
    localparam int ACC_W    = DATA_W + ENT_W;

    typedef enum logic [OP_W-1:0] {
        OP_DESC  = 2'd0,
        OP_POINT = 2'd1,
        OP_EVAL  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] tm;
        vec_t                     v;
    } point_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - ACC_W'(1);
        if (a > hi)
            return {1'b0, {(DATA_W-1){1'b1}}};
        else if (a < lo)
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return a[DATA_W-1:0];
    endfunction

endpackage

// ----- hdl/tfi_item_if.sv -----
// Input item channel: valid/ready plus the command payload.
// Depends on tfi_pkg.
interface tfi_item_if
    import tfi_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [ENT_W-1:0]          entry_slot;
    logic [PT_W-1:0]           point_slot;
    logic signed [BEADN_W-1:0] bead_number;
    logic                      is_constant;
    logic                      entry_active;
    logic [NPT_W-1:0]          point_total;
    logic signed [DATA_W-1:0]  time_value;
    logic signed [DATA_W-1:0]  in_force_x;
    logic signed [DATA_W-1:0]  in_force_y;
    logic signed [DATA_W-1:0]  in_force_z;

    modport source (output valid, operation, entry_slot, point_slot, bead_number,
                    is_constant, entry_active, point_total, time_value,
                    in_force_x, in_force_y, in_force_z, input ready);
    modport sink   (input valid, operation, entry_slot, point_slot, bead_number,
                    is_constant, entry_active, point_total, time_value,
                    in_force_x, in_force_y, in_force_z, output ready);
endinterface

// ----- hdl/tfi_result_if.sv -----
// Result channel: valid/ready plus one per-bead force sum.
// Depends on tfi_pkg.
interface tfi_result_if
    import tfi_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OBEAD_W-1:0]       out_bead;
    logic signed [DATA_W-1:0] out_force_x;
    logic signed [DATA_W-1:0] out_force_y;
    logic signed [DATA_W-1:0] out_force_z;
    logic                     last_bead;

    modport source (output valid, out_bead, out_force_x, out_force_y, out_force_z,
                    last_bead, input ready);
    modport sink   (input valid, out_bead, out_force_x, out_force_y, out_force_z,
                    last_bead, output ready);
endinterface

// ----- hdl/tfi_cfg_if.sv -----
// Configuration write channel carrying bead_count.
// Depends on tfi_pkg.
interface tfi_cfg_if
    import tfi_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/tfi_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tfi_pkg. Quotient must fit in DATA_W bits.
module tfi_div
    import tfi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2*DATA_W-1:0]   dividend,
    input  logic [DATA_W-1:0]     divisor,
    output logic                  done,
    output logic [DATA_W-1:0]     quotient
);
    localparam int STEP_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DATA_W-1]};
        if (start)
        begin
            rem_next = dividend[2*DATA_W-1:DATA_W];
            quo_next = dividend[DATA_W-1:0];
            dvs_next = divisor;
            cnt_next = STEP_W'(DATA_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DATA_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_W'(1);
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- hdl/tabulated_force_interpolator_top.sv -----
// Tabulated force interpolator, top level.
// Depends on tfi_pkg, tfi_item_if, tfi_result_if, tfi_cfg_if and tfi_div.
//
// Channels: items (sink) carries descriptor writes, table point writes and
// evaluate commands; results (source) carries one transaction per bead;
// cfg (sink) writes bead_count and is always ready.
// Writes are stored as they are accepted. An evaluation first resolves
// every entry's vector in turn: a constant or disabled entry directly, a
// table entry by a segment walk through the point memory's one read
// port, plus one 32x32 multiply and a 32-step shared divider per axis
// when it interpolates. Then each bead sums over all MAX_ENTRIES entries
// and issues its result transaction.
// items.ready is high only while idle; one item is worked at a time.
// When results stalls, the block holds the current result and waits.
// Reset clears the entry enables and sets bead_count to 1; table and
// descriptor storage is not cleared.
module tabulated_force_interpolator_top
    import tfi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    tfi_item_if.sink     items,
    tfi_result_if.source results,
    tfi_cfg_if.sink      cfg
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_ENT   = 13'b0000000000010,
        S_RL    = 13'b0000000000100,
        S_GL    = 13'b0000000001000,
        S_R0    = 13'b0000000010000,
        S_G0    = 13'b0000000100000,
        S_RW    = 13'b0000001000000,
        S_GW    = 13'b0000010000000,
        S_MUL   = 13'b0000100000000,
        S_DIV   = 13'b0001000000000,
        S_DWAIT = 13'b0010000000000,
        S_SUM   = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         bead_count_reg;
    logic [MAX_ENTRIES-1:0]   slot_en_reg;
    logic signed [BEADN_W-1:0] slot_bead_reg [MAX_ENTRIES];
    logic                     slot_const_reg [MAX_ENTRIES];
    logic [NPT_W-1:0]         slot_pts_reg [MAX_ENTRIES];
    vec_t                     const_vec_reg [MAX_ENTRIES];
    vec_t                     ent_vec_reg [MAX_ENTRIES];
    point_t                   tab_mem [TAB_DEPTH];
    point_t                   rdata_reg;

    logic signed [DATA_W-1:0] t_reg, t_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [ENT_W-1:0]         ent_reg, ent_next;
    logic [PT_W-1:0]          ptr_reg, ptr_next;
    logic [1:0]               comp_reg, comp_next;
    logic [OBEAD_W-1:0]       bead_reg, bead_next;
    point_t                   prev_reg, prev_next;
    point_t                   cur_reg, cur_next;
    point_t                   last_reg, last_next;
    logic [2*DATA_W-1:0]      prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic signed [ACC_W-1:0]  accx_reg, accx_next;
    logic signed [ACC_W-1:0]  accy_reg, accy_next;
    logic signed [ACC_W-1:0]  accz_reg, accz_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OBEAD_W-1:0]       out_bead_reg, out_bead_next;
    vec_t                     out_vec_reg, out_vec_next;
    logic                     out_last_reg, out_last_next;

    logic                     vec_all_we;
    vec_t                     vec_all_val;
    logic                     vec_one_we;
    logic signed [DATA_W-1:0] lerp_val;
    logic                     ent_done;
    logic                     div_start;
    logic                     div_done;
    logic [DATA_W-1:0]        div_q;

    logic                     in_fire;
    logic [NPT_W-1:0]         cur_pts;
    logic signed [DATA_W-1:0] v0, v1;
    logic signed [DATA_W:0]   dv;
    logic [DATA_W:0]          dv_abs;
    logic [DATA_W:0]          dt_full;
    logic [DATA_W:0]          span_full;
    logic signed [CNT_W:0]    bead_res;
    logic                     hit;
    logic signed [ACC_W-1:0]  sumx, sumy, sumz;

    assign in_fire = items.valid && items.ready;
    assign cur_pts = slot_pts_reg[ent_reg];

    always_comb
    begin
        case (comp_reg)
            2'd0:    begin v0 = prev_reg.v.x; v1 = cur_reg.v.x; end
            2'd1:    begin v0 = prev_reg.v.y; v1 = cur_reg.v.y; end
            default: begin v0 = prev_reg.v.z; v1 = cur_reg.v.z; end
        endcase
    end

    assign dv        = {v1[DATA_W-1], v1} - {v0[DATA_W-1], v0};
    assign dv_abs    = dv[DATA_W] ? (DATA_W+1)'(-dv) : dv;
    assign dt_full   = {t_reg[DATA_W-1], t_reg} - {prev_reg.tm[DATA_W-1], prev_reg.tm};
    assign span_full = {cur_reg.tm[DATA_W-1], cur_reg.tm}
                       - {prev_reg.tm[DATA_W-1], prev_reg.tm};
    assign lerp_val  = neg_reg ? DATA_W'({v0[DATA_W-1], v0} - {1'b0, div_q})
                               : DATA_W'({v0[DATA_W-1], v0} + {1'b0, div_q});

    // bead index of the selected entry, negative values counted back from n
    assign bead_res = slot_bead_reg[ent_reg][BEADN_W-1]
                      ? $signed({1'b0, n_reg}) + (CNT_W+1)'(slot_bead_reg[ent_reg])
                      : (CNT_W+1)'(slot_bead_reg[ent_reg]);
    assign hit = slot_en_reg[ent_reg] && (bead_res == $signed({2'b00, bead_reg}));

    assign sumx = hit ? accx_reg + ACC_W'(ent_vec_reg[ent_reg].x) : accx_reg;
    assign sumy = hit ? accy_reg + ACC_W'(ent_vec_reg[ent_reg].y) : accy_reg;
    assign sumz = hit ? accz_reg + ACC_W'(ent_vec_reg[ent_reg].z) : accz_reg;

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        n_next         = n_reg;
        ent_next       = ent_reg;
        ptr_next       = ptr_reg;
        comp_next      = comp_reg;
        bead_next      = bead_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        accx_next      = accx_reg;
        accy_next      = accy_reg;
        accz_next      = accz_reg;
        out_valid_next = out_valid_reg;
        out_bead_next  = out_bead_reg;
        out_vec_next   = out_vec_reg;
        out_last_next  = out_last_reg;
        vec_all_we     = 1'b0;
        vec_all_val    = '0;
        vec_one_we     = 1'b0;
        ent_done       = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && op_t'(items.operation) == OP_EVAL)
                begin
                    t_next   = items.time_value;
                    n_next   = (bead_count_reg > CNT_W'(MAX_BEADS)) ? CNT_W'(MAX_BEADS)
                                                                    : bead_count_reg;
                    ent_next = '0;
                    if (bead_count_reg != '0)
                        state_next = S_ENT;
                end
            end
            S_ENT:
            begin
                if (slot_en_reg[ent_reg] && !slot_const_reg[ent_reg] && cur_pts != '0)
                begin
                    ptr_next   = PT_W'(cur_pts - NPT_W'(1));
                    state_next = S_RL;
                end
                else
                begin
                    vec_all_we = 1'b1;
                    if (slot_const_reg[ent_reg])
                        vec_all_val = const_vec_reg[ent_reg];
                    ent_done = 1'b1;
                end
            end
            S_RL:
                state_next = S_GL;
            S_GL:
            begin
                last_next  = rdata_reg;
                ptr_next   = '0;
                state_next = S_R0;
            end
            S_R0:
                state_next = S_G0;
            S_G0:
            begin
                prev_next = rdata_reg;
                if (cur_pts == NPT_W'(1) || t_reg <= rdata_reg.tm)
                begin
                    vec_all_we  = 1'b1;
                    vec_all_val = rdata_reg.v;
                    ent_done    = 1'b1;
                end
                else if (t_reg >= last_reg.tm)
                begin
                    vec_all_we  = 1'b1;
                    vec_all_val = last_reg.v;
                    ent_done    = 1'b1;
                end
                else
                begin
                    ptr_next   = PT_W'(1);
                    state_next = S_RW;
                end
            end
            S_RW:
                state_next = S_GW;
            S_GW:
            begin
                if (t_reg >= prev_reg.tm && t_reg < rdata_reg.tm)
                begin
                    cur_next   = rdata_reg;
                    comp_next  = 2'd0;
                    state_next = S_MUL;
                end
                else if ({1'b0, ptr_reg} == NPT_W'(cur_pts - NPT_W'(1)))
                begin
                    vec_all_we  = 1'b1;
                    vec_all_val = last_reg.v;
                    ent_done    = 1'b1;
                end
                else
                begin
                    prev_next  = rdata_reg;
                    ptr_next   = ptr_reg + PT_W'(1);
                    state_next = S_RW;
                end
            end
            S_MUL:
            begin
                prod_next  = dv_abs[DATA_W-1:0] * dt_full[DATA_W-1:0];
                neg_next   = dv[DATA_W];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    vec_one_we = 1'b1;
                    if (comp_reg == 2'd2)
                        ent_done = 1'b1;
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_SUM:
            begin
                accx_next = sumx;
                accy_next = sumy;
                accz_next = sumz;
                if (ent_reg == ENT_W'(MAX_ENTRIES - 1))
                begin
                    out_valid_next = 1'b1;
                    out_bead_next  = bead_reg;
                    out_vec_next   = '{x: sat32(sumx), y: sat32(sumy), z: sat32(sumz)};
                    out_last_next  = ({1'b0, bead_reg} == CNT_W'(n_reg - CNT_W'(1)));
                    state_next     = S_EMIT;
                end
                else
                    ent_next = ent_reg + ENT_W'(1);
            end
            S_EMIT:
            begin
                if (results.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        bead_next  = bead_reg + OBEAD_W'(1);
                        ent_next   = '0;
                        accx_next  = '0;
                        accy_next  = '0;
                        accz_next  = '0;
                        state_next = S_SUM;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (ent_done)
        begin
            if (ent_reg == ENT_W'(MAX_ENTRIES - 1))
            begin
                ent_next   = '0;
                bead_next  = '0;
                accx_next  = '0;
                accy_next  = '0;
                accz_next  = '0;
                state_next = S_SUM;
            end
            else
            begin
                ent_next   = ent_reg + ENT_W'(1);
                state_next = S_ENT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bead_count_reg <= CNT_W'(1);
            slot_en_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                bead_count_reg <= cfg.data;
            if (in_fire && op_t'(items.operation) == OP_DESC)
                slot_en_reg[items.entry_slot] <= items.entry_active;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        n_reg        <= n_next;
        ent_reg      <= ent_next;
        ptr_reg      <= ptr_next;
        comp_reg     <= comp_next;
        bead_reg     <= bead_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        last_reg     <= last_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        accx_reg     <= accx_next;
        accy_reg     <= accy_next;
        accz_reg     <= accz_next;
        out_bead_reg <= out_bead_next;
        out_vec_reg  <= out_vec_next;
        out_last_reg <= out_last_next;

        if (in_fire && op_t'(items.operation) == OP_DESC)
        begin
            slot_bead_reg[items.entry_slot]  <= items.bead_number;
            slot_const_reg[items.entry_slot] <= items.is_constant;
            slot_pts_reg[items.entry_slot]   <= (items.point_total > NPT_W'(MAX_POINTS))
                                                ? NPT_W'(MAX_POINTS) : items.point_total;
            const_vec_reg[items.entry_slot]  <= '{x: items.in_force_x, y: items.in_force_y,
                                                  z: items.in_force_z};
        end

        if (vec_all_we)
            ent_vec_reg[ent_reg] <= vec_all_val;
        else if (vec_one_we)
        begin
            case (comp_reg)
                2'd0:    ent_vec_reg[ent_reg].x <= lerp_val;
                2'd1:    ent_vec_reg[ent_reg].y <= lerp_val;
                default: ent_vec_reg[ent_reg].z <= lerp_val;
            endcase
        end
    end

    // table point memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (in_fire && op_t'(items.operation) == OP_POINT)
            tab_mem[{items.entry_slot, items.point_slot}] <=
                '{tm: items.time_value,
                  v: '{x: items.in_force_x, y: items.in_force_y, z: items.in_force_z}};
        rdata_reg <= tab_mem[{ent_reg, ptr_reg}];
    end

    tfi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (span_full[DATA_W-1:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    assign items.ready         = (state_reg == S_IDLE);
    assign cfg.ready           = 1'b1;
    assign results.valid       = out_valid_reg;
    assign results.out_bead    = out_bead_reg;
    assign results.out_force_x = out_vec_reg.x;
    assign results.out_force_y = out_vec_reg.y;
    assign results.out_force_z = out_vec_reg.z;
    assign results.last_bead   = out_last_reg;

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        items.ready |-> !results.valid)
        else $error("input accepted while a result is pending");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DWAIT)
        else $error("divider finished outside its wait state");

    a_last_bead: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.last_bead |->
            {1'b0, results.out_bead} == CNT_W'(n_reg - CNT_W'(1)))
        else $error("last marker on wrong bead");

    a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> state_reg == S_EMIT)
        else $error("result shown outside emit state");
endmodule
